/* rtl/pdw_pkg.sv */
// pdw_pkg: shared constants for the packet duplicate window
// no dependencies; imported by packet_duplicate_window and pdw_checker
package pdw_pkg;

  // window size in packet ids, counting the newest recorded id and those behind it
  localparam int unsigned WIN_BITS = 64;
  // index width into the window bitmap
  localparam int unsigned IDX_W    = (WIN_BITS > 1) ? $clog2(WIN_BITS) : 1;
  // packet id width and the half-range distance that counts as behind
  localparam int unsigned ID_W     = 16;
  localparam logic [ID_W-1:0] HALF_RANGE = 16'h8000;
  // window size as a 17-bit value for distance compares
  localparam logic [ID_W:0]   WIN_LIM    = (ID_W + 1)'(WIN_BITS);

  // opcode values
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  // stream payload widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

endpackage

/* rtl/packet_duplicate_window.sv */
// packet_duplicate_window: sliding bitmap anti-replay check on 16-bit packet ids
// depends on pdw_pkg
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready   | tdata: seq_id, tuser: opcode
//  out_    | master    | out_tvalid / out_tready | tdata: dup_flag
//
// one request per cycle sustained while out_tready stays high; each request waits in the input
// register, is judged and recorded there, and its verdict sits in the result register
// out_tvalid rises once the request moves from the input register into the result register
// rst_n clears started, newest id, the bitmap and both valid flags
// a stalled result holds; the input register still fills, then in_tready drops
module packet_duplicate_window
  import pdw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] seq_id
  input  logic                   in_tuser,   // [0] opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [0] dup_flag, [7:1] zero
);

  // input register
  logic            s1_valid_r;
  logic [ID_W-1:0] s1_id_r;
  logic            s1_op_r;

  // window state
  logic                started_r,  started_nxt;
  logic [ID_W-1:0]     newest_r,   newest_nxt;
  logic [WIN_BITS-1:0] bitmap_r,   bitmap_nxt;

  // result register
  logic out_valid_r;
  logic out_dup_r;

  logic            s1_adv;
  logic            in_acc;
  logic [ID_W-1:0] fwd;
  logic [ID_W-1:0] back;
  logic [IDX_W-1:0] back_idx;
  logic            ahead;
  logic            back_old;
  logic            fwd_far;
  logic            dup;

  // handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // distances to the newest id
  assign fwd      = s1_id_r - newest_r;
  assign back     = newest_r - s1_id_r;
  assign back_idx = back[IDX_W-1:0];
  assign ahead    = (fwd != '0) && (fwd < HALF_RANGE);
  assign back_old = {1'b0, back} >= WIN_LIM;
  assign fwd_far  = {1'b0, fwd} >= WIN_LIM;

  // verdict against the state before any update
  always_comb begin
    if (!started_r || ahead) begin
      dup = 1'b0;
    end else if (back_old) begin
      dup = 1'b1;
    end else begin
      dup = bitmap_r[back_idx];
    end
  end

  // window update for a record request
  always_comb begin
    started_nxt = started_r;
    newest_nxt  = newest_r;
    bitmap_nxt  = bitmap_r;
    if (s1_adv && s1_op_r == OP_RECORD) begin
      if (!started_r) begin
        started_nxt = 1'b1;
        newest_nxt  = s1_id_r;
        bitmap_nxt  = WIN_BITS'(1);
      end else if (fwd == '0) begin
        bitmap_nxt = bitmap_r | WIN_BITS'(1);
      end else if (ahead) begin
        newest_nxt = s1_id_r;
        if (fwd_far) begin
          bitmap_nxt = WIN_BITS'(1);
        end else begin
          bitmap_nxt = (bitmap_r << fwd) | WIN_BITS'(1);
        end
      end else if (!back_old) begin
        bitmap_nxt = bitmap_r | (WIN_BITS'(1) << back_idx);
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      newest_r    <= '0;
      bitmap_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      started_r <= started_nxt;
      newest_r  <= newest_nxt;
      bitmap_r  <= bitmap_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_id_r <= in_tdata[ID_W-1:0];
      s1_op_r <= in_tuser;
    end
    if (s1_adv) begin
      out_dup_r <= dup;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_dup_r};

endmodule

/* rtl/pdw_checker.sv */
// pdw_checker: port-level checks for packet_duplicate_window, bound into that module
// depends on pdw_pkg
module pdw_checker
  import pdw_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       rec_seen_r;
  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // track record requests seen and requests in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_seen_r <= 1'b0;
      pend_r     <= '0;
    end else begin
      if (in_acc && in_tuser == OP_RECORD) begin
        rec_seen_r <= 1'b1;
      end
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // a stalled result holds its verdict
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no verdict can be a duplicate before any record request
  a_no_dup_before_rec: assert property (@(posedge clk) disable iff (!rst_n)
    !rec_seen_r && out_tvalid |-> out_tdata[0] == 1'b0)
    else $error("duplicate reported before first record");

  // input only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // at most two requests in flight, and a result only for a pending request
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2 && (!out_tvalid || pend_r != 2'd0))
    else $error("in-flight request count out of range");

endmodule

bind packet_duplicate_window pdw_checker u_pdw_checker (.*);
